[rtl/core/csum_pkg.sv]
// shared types and constants for the compensated float summation block
// no dependencies
`default_nettype none

package csum_pkg;

	localparam logic [63:0] NAN_F64 = 64'hFFF8_0000_0000_0000;
	localparam logic [31:0] NAN_F32 = 32'hFFC0_0000;
	localparam logic [10:0] EXP_ONES_F64 = 11'h7FF;
	localparam logic [10:0] EXP_ONES_F32 = 11'h0FF;
	localparam logic [11:0] EXP_MAX_F64 = 12'd2046;
	localparam logic [11:0] EXP_MAX_F32 = 12'd254;

	localparam logic REG_DOUBLE = 1'b0;
	localparam logic REG_COMPENSATE = 1'b1;

	typedef struct packed {
		logic [63:0] value;
		logic        last;
		logic        dp;
		logic        comp;
	} csum_item_t;

	typedef struct packed {
		logic        valid;
		logic        dp;
		logic        sub;
		logic [63:0] a;
		logic [63:0] b;
	} csum_add_req_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_Y,
		SQ_T,
		SQ_D,
		SQ_C,
		SQ_P,
		SQ_HOLD
	} csum_seq_t;

endpackage

`default_nettype wire

[rtl/core/csum_front.sv]
// front end: takes input beats, tags them with the current format and mode, queues them
// depends on csum_pkg
`default_nettype none

module csum_front #(
	parameter int DEPTH = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [63:0]          in_value,
	input  wire                  in_last,
	input  wire                  cfg_dp,
	input  wire                  cfg_comp,
	output logic                 q_valid,
	output csum_pkg::csum_item_t q_item,
	input  wire                  q_pop
);
	import csum_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	csum_item_t     mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;
	csum_item_t     item_in;

	assign in_ready = (count_q != CW'(DEPTH));
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_comb begin
		item_in.value = cfg_dp ? in_value : {32'b0, in_value[31:0]};
		item_in.last  = in_last;
		item_in.dp    = cfg_dp;
		item_in.comp  = cfg_comp;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/csum_fadd.sv]
// two-stage binary32/binary64 adder, round to nearest even
// stage 1 aligns and adds, stage 2 normalizes, rounds and packs; depends on csum_pkg
`default_nettype none

module csum_fadd (
	input  wire                     clk,
	input  wire                     arst_n,
	input  csum_pkg::csum_add_req_t req,
	output logic                    res_valid,
	output logic [63:0]             res
);
	import csum_pkg::*;

	// stage 1 signals
	logic        sa, sb;
	logic [10:0] efa, efb, ea, eb, eones;
	logic [52:0] fa, fb;
	logic [52:0] ma, mb;
	logic        a_nan, b_nan, a_inf, b_inf;
	logic        a_big;
	logic        s_big, s_sml;
	logic [10:0] e_big, e_sml, diff;
	logic [52:0] m_big, m_sml;
	logic [5:0]  sh_al;
	logic [55:0] ext_sml, shifted, lostmask, al_sml;
	logic        effsub;
	logic [56:0] sum;
	logic        sign_a;
	logic        spec;
	logic [63:0] spec_val;
	logic [63:0] qa, qb;

	logic        valid_s1, dp_s1, sign_s1, spec_s1;
	logic [10:0] exp_s1;
	logic [56:0] sum_s1;
	logic [63:0] spec_s1_val;

	// stage 2 signals
	logic [5:0]  lz;
	logic [10:0] lim, sh;
	logic [55:0] v;
	logic [11:0] e;
	logic [52:0] m53;
	logic        g, st, up;
	logic [53:0] m54;
	logic        carry_r, hidden, ovf;
	logic [11:0] e2;
	logic [11:0] efield;
	logic [63:0] packed_res;

	logic        valid_s2;
	logic [63:0] res_s2;

	always_comb begin
		if (req.dp) begin
			sa = req.a[63]; efa = req.a[62:52]; fa = {1'b0, req.a[51:0]};
			sb = req.b[63]; efb = req.b[62:52]; fb = {1'b0, req.b[51:0]};
			eones = EXP_ONES_F64;
			qa = req.a | 64'h0008_0000_0000_0000;
			qb = req.b | 64'h0008_0000_0000_0000;
		end else begin
			sa = req.a[31]; efa = {3'b0, req.a[30:23]}; fa = {1'b0, req.a[22:0], 29'b0};
			sb = req.b[31]; efb = {3'b0, req.b[30:23]}; fb = {1'b0, req.b[22:0], 29'b0};
			eones = EXP_ONES_F32;
			qa = {32'b0, req.a[31:0] | 32'h0040_0000};
			qb = {32'b0, req.b[31:0] | 32'h0040_0000};
		end
		sb = sb ^ req.sub;
		a_nan = (efa == eones) && (fa != '0);
		b_nan = (efb == eones) && (fb != '0);
		a_inf = (efa == eones) && (fa == '0);
		b_inf = (efb == eones) && (fb == '0);
		ma = {efa != '0, fa[51:0]};
		mb = {efb != '0, fb[51:0]};
		ea = (efa == '0) ? 11'd1 : efa;
		eb = (efb == '0) ? 11'd1 : efb;

		a_big = ({ea, ma} >= {eb, mb});
		s_big = a_big ? sa : sb;
		s_sml = a_big ? sb : sa;
		e_big = a_big ? ea : eb;
		e_sml = a_big ? eb : ea;
		m_big = a_big ? ma : mb;
		m_sml = a_big ? mb : ma;
		diff  = e_big - e_sml;
		sh_al = (diff > 11'd63) ? 6'd63 : diff[5:0];
		ext_sml  = {m_sml, 3'b0};
		shifted  = ext_sml >> sh_al;
		lostmask = ~({56{1'b1}} << sh_al);
		al_sml   = shifted | {55'b0, (ext_sml & lostmask) != '0};
		effsub   = s_big ^ s_sml;
		sum = effsub ? ({1'b0, m_big, 3'b0} - {1'b0, al_sml})
		             : ({1'b0, m_big, 3'b0} + {1'b0, al_sml});
		sign_a = (sum == '0) ? (effsub ? 1'b0 : s_big) : s_big;

		spec = a_nan || b_nan || a_inf || b_inf;
		if (a_nan) begin
			spec_val = qa;
		end else if (b_nan) begin
			spec_val = qb;
		end else if (a_inf && b_inf && (sa != sb)) begin
			spec_val = req.dp ? NAN_F64 : {32'b0, NAN_F32};
		end else if (req.dp) begin
			spec_val = {a_inf ? sa : sb, EXP_ONES_F64, 52'b0};
		end else begin
			spec_val = {32'b0, a_inf ? sa : sb, EXP_ONES_F32[7:0], 23'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			dp_s1       <= req.dp;
			sign_s1     <= sign_a;
			spec_s1     <= spec;
			exp_s1      <= e_big;
			sum_s1      <= sum;
			spec_s1_val <= spec_val;
		end
	end

	always_comb begin
		lz = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (sum_s1[i]) begin
				lz = 6'(55 - i);
			end
		end
		lim = exp_s1 - 11'd1;
		sh  = ({5'b0, lz} < lim) ? {5'b0, lz} : lim;
		if (sum_s1[56]) begin
			v = {sum_s1[56:2], sum_s1[1] | sum_s1[0]};
			e = {1'b0, exp_s1} + 12'd1;
		end else begin
			v = sum_s1[55:0] << sh;
			e = {1'b0, exp_s1} - {1'b0, sh};
		end
		if (dp_s1) begin
			m53 = v[55:3];
			g   = v[2];
			st  = |v[1:0];
		end else begin
			m53 = {29'b0, v[55:32]};
			g   = v[31];
			st  = |v[30:0];
		end
		up      = g && (st || m53[0]);
		m54     = {1'b0, m53} + {53'b0, up};
		carry_r = dp_s1 ? m54[53] : m54[24];
		hidden  = carry_r || (dp_s1 ? m54[52] : m54[23]);
		e2      = e + {11'b0, carry_r};
		efield  = hidden ? e2 : 12'd0;
		ovf     = hidden && (e2 > (dp_s1 ? EXP_MAX_F64 : EXP_MAX_F32));
		if (spec_s1) begin
			packed_res = spec_s1_val;
		end else if (dp_s1) begin
			packed_res = ovf ? {sign_s1, EXP_ONES_F64, 52'b0}
			                 : {sign_s1, efield[10:0], m54[51:0]};
		end else begin
			packed_res = ovf ? {32'b0, sign_s1, EXP_ONES_F32[7:0], 23'b0}
			                 : {32'b0, sign_s1, efield[7:0], m54[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= packed_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

[rtl/core/csum_back.sv]
// back end: sequences the additions of one item on the shared adder, holds sum and
// compensation, drives the result register; depends on csum_pkg
`default_nettype none

module csum_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      q_valid,
	input  csum_pkg::csum_item_t     q_item,
	output logic                     q_pop,
	output csum_pkg::csum_add_req_t  add_req,
	input  wire                      add_valid,
	input  wire  [63:0]              add_res,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [63:0]              out_total
);
	import csum_pkg::*;

	csum_seq_t   state_q, state_d;
	csum_item_t  item_q;
	logic [63:0] sum_q, err_q, y_q, t_q;
	logic        out_valid_q;
	logic [63:0] out_total_q;
	logic        out_free;
	logic        finish;
	logic        emit;
	logic [63:0] new_sum, new_err;

	assign out_free = !out_valid_q || out_ready;
	assign finish   = ((state_q == SQ_C) || (state_q == SQ_P)) && add_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: if (q_valid) state_d = q_item.comp ? SQ_Y : SQ_P;
			SQ_Y:    if (add_valid) state_d = SQ_T;
			SQ_T:    if (add_valid) state_d = SQ_D;
			SQ_D:    if (add_valid) state_d = SQ_C;
			SQ_C, SQ_P: begin
				if (add_valid) begin
					state_d = (item_q.last && !out_free) ? SQ_HOLD : SQ_IDLE;
				end
			end
			SQ_HOLD: if (out_free) state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		q_pop         = 1'b0;
		add_req.valid = 1'b0;
		add_req.dp    = item_q.dp;
		add_req.sub   = 1'b0;
		add_req.a     = sum_q;
		add_req.b     = add_res;
		emit          = 1'b0;
		new_sum       = (state_q == SQ_C) ? t_q : add_res;
		new_err       = (state_q == SQ_C) ? add_res : err_q;
		unique case (state_q)
			SQ_IDLE: begin
				q_pop         = q_valid;
				add_req.valid = q_valid;
				add_req.dp    = q_item.dp;
				add_req.sub   = q_item.comp;
				add_req.a     = q_item.comp ? q_item.value : sum_q;
				add_req.b     = q_item.comp ? err_q : q_item.value;
			end
			SQ_Y: begin
				add_req.valid = add_valid;
			end
			SQ_T: begin
				add_req.valid = add_valid;
				add_req.sub   = 1'b1;
				add_req.a     = add_res;
				add_req.b     = sum_q;
			end
			SQ_D: begin
				add_req.valid = add_valid;
				add_req.sub   = 1'b1;
				add_req.a     = add_res;
				add_req.b     = y_q;
			end
			SQ_C, SQ_P: begin
				emit = add_valid && item_q.last && out_free;
			end
			SQ_HOLD: begin
				emit    = out_free;
				new_sum = sum_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if ((state_q == SQ_Y) && add_valid) begin
			y_q <= add_res;
		end
		if ((state_q == SQ_T) && add_valid) begin
			t_q <= add_res;
		end
		if (emit) begin
			out_total_q <= new_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			sum_q       <= '0;
			err_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				sum_q <= '0;
				err_q <= '0;
			end else if (finish) begin
				sum_q <= new_sum;
				err_q <= new_err;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_total = out_total_q;

endmodule

`default_nettype wire

[rtl/core/compensated_float_summation.sv]
// Running sum of IEEE-754 values, binary32 or binary64, plain or Kahan compensated.
// Each beat's value is added to the sum; on a beat with tlast the sum goes out on
// m_tdata and sum and compensation clear. One shared two-stage adder does all
// additions: a compensated item takes four dependent additions, a plain item one
// addition; an item starts only when the one before it is done. Input beats queue
// in front of the adder sequencer (QUEUE_DEPTH entries) and the result sits in its
// own register. Depends on csum_pkg, csum_front, csum_fadd, csum_back.
`default_nettype none

module compensated_float_summation #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // value [63:0]
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,   // total [63:0]
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire         cfg_data
);
	import csum_pkg::*;

	logic          dp_q;
	logic          comp_q;
	logic          q_valid;
	logic          q_pop;
	csum_item_t    q_item;
	csum_add_req_t add_req;
	logic          add_valid;
	logic [63:0]   add_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q   <= 1'b0;
			comp_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DOUBLE:    dp_q   <= cfg_data;
				REG_COMPENSATE: comp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	csum_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_value (s_tdata),
		.in_last  (s_tlast),
		.cfg_dp   (dp_q),
		.cfg_comp (comp_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	csum_fadd u_fadd (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (add_req),
		.res_valid (add_valid),
		.res       (add_res)
	);

	csum_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.add_req   (add_req),
		.add_valid (add_valid),
		.add_res   (add_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_total (m_tdata)
	);

endmodule

`default_nettype wire

[tb/compensated_float_summation_tb.sv]
// self-checking testbench for compensated_float_summation: drives value beats in
// sequences, predicts each total with a bit-exact soft-float adder, checks m_tdata
// depends on csum_pkg and the compensated_float_summation rtl
`default_nettype none

module compensated_float_summation_tb;
	import csum_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [63:0] value;
		logic        last;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic        cfg_data;

	beat_t       pending_beats[$];
	logic [63:0] expected_totals[$];
	logic [63:0] sum_bits;
	logic [63:0] err_bits;
	bit          use_double;
	bit          use_kahan;
	bit          s_took;
	bit          calm;
	bit          hold_req;
	int          hold_cnt;
	int          mismatches;
	int          stall_cycles;

	compensated_float_summation u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit is_nan(input logic [63:0] v, input bit dp);
		if (dp)
			return v[62:52] == 11'h7FF && v[51:0] != 0;
		return v[63:32] == 0 && v[30:23] == 8'hFF && v[22:0] != 0;
	endfunction

	// round-to-nearest-even addition on binary32 (low bits) or binary64 patterns
	function automatic logic [63:0] fp_add(input logic [63:0] a, input logic [63:0] b,
			input bit dp);
		int          fw;
		int          emax;
		int          ea;
		int          eb;
		int          e;
		int          d;
		bit          sa;
		bit          sb;
		bit          up;
		logic [63:0] fa;
		logic [63:0] fb;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] tmp;
		logic [63:0] sum;
		fw = dp ? 52 : 23;
		emax = dp ? 2047 : 255;
		sa = dp ? a[63] : a[31];
		sb = dp ? b[63] : b[31];
		ea = dp ? int'(a[62:52]) : int'(a[30:23]);
		eb = dp ? int'(b[62:52]) : int'(b[30:23]);
		fa = a & ((64'd1 << fw) - 1);
		fb = b & ((64'd1 << fw) - 1);
		if ((ea == emax && fa != 0) || (eb == emax && fb != 0) ||
				(ea == emax && eb == emax && sa != sb))
			return dp ? NAN_F64 : {32'd0, NAN_F32};
		if (ea == emax)
			return dp ? a : {32'd0, a[31:0]};
		if (eb == emax)
			return dp ? b : {32'd0, b[31:0]};
		ma = (fa | (ea != 0 ? (64'd1 << fw) : 64'd0)) << 3;
		mb = (fb | (eb != 0 ? (64'd1 << fw) : 64'd0)) << 3;
		if (ea == 0) ea = 1;
		if (eb == 0) eb = 1;
		if (eb > ea || (eb == ea && mb > ma)) begin
			tmp = ma; ma = mb; mb = tmp;
			d = ea; ea = eb; eb = d;
			up = sa; sa = sb; sb = up;
		end
		d = ea - eb;
		if (d > fw + 5)
			mb = (mb != 0) ? 64'd1 : 64'd0;
		else if (d > 0)
			mb = (mb >> d) | (((mb & ((64'd1 << d) - 1)) != 0) ? 64'd1 : 64'd0);
		e = ea;
		if (sa == sb) begin
			sum = ma + mb;
			if (sum[fw + 4]) begin
				sum = (sum >> 1) | {63'd0, sum[0]};
				e++;
			end
		end else begin
			sum = ma - mb;
			if (sum == 0)
				return 64'd0;
			while (!sum[fw + 3] && e > 1) begin
				sum = sum << 1;
				e--;
			end
		end
		up = sum[2] && (sum[1] || sum[0] || sum[3]);
		sum = (sum >> 3) + (up ? 64'd1 : 64'd0);
		if (sum[fw + 1]) begin
			sum = sum >> 1;
			e++;
		end
		if (e >= emax)
			return dp ? {sa, 11'h7FF, 52'd0} : {32'd0, sa, 8'hFF, 23'd0};
		if (!sum[fw])
			e = 0;
		if (dp)
			return {sa, e[10:0], sum[51:0]};
		return {32'd0, sa, e[7:0], sum[22:0]};
	endfunction

	function automatic logic [63:0] fp_sub(input logic [63:0] a, input logic [63:0] b,
			input bit dp);
		logic [63:0] nb;
		nb = b;
		if (dp)
			nb[63] = ~nb[63];
		else
			nb[31] = ~nb[31];
		return fp_add(a, nb, dp);
	endfunction

	// advance the running sum by one beat, queue the total on a last beat
	task automatic accumulate(input logic [63:0] value, input logic last);
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] c;
		logic [63:0] y;
		logic [63:0] t;
		x = use_double ? value : {32'd0, value[31:0]};
		s = use_double ? sum_bits : {32'd0, sum_bits[31:0]};
		c = use_double ? err_bits : {32'd0, err_bits[31:0]};
		if (use_kahan) begin
			y = fp_sub(x, c, use_double);
			t = fp_add(s, y, use_double);
			err_bits = fp_sub(fp_sub(t, s, use_double), y, use_double);
			sum_bits = t;
		end else begin
			sum_bits = fp_add(s, x, use_double);
		end
		if (last) begin
			expected_totals.push_back(use_double ? sum_bits : {32'd0, sum_bits[31:0]});
			sum_bits = 0;
			err_bits = 0;
		end
	endtask

	function automatic logic [63:0] rand_value(input bit dp);
		int          r;
		logic [63:0] v;
		r = $urandom_range(0, 99);
		v = {$urandom, $urandom};
		if (r < 6) begin
			case ($urandom_range(0, 5))
				0: v[62:0] = 0;
				1: v[62:0] = dp ? {11'h7FF, 52'd0} : {v[62:31], 8'hFF, 23'd0};
				2: v[62:0] = dp ? {11'h7FF, 52'd1} : {v[62:31], 8'hFF, 23'd1};
				3: v[62:0] = dp ? {11'h7FE, {52{1'b1}}} : {v[62:31], 8'hFE, {23{1'b1}}};
				4: v[62:0] = dp ? 63'd1 : {v[62:31], 31'd1};
				default: v[62:0] = dp ? {11'd0, v[51:0]} : {v[62:31], 8'd0, v[22:0]};
			endcase
			if (!dp) v[31] = v[63];
		end else if (r >= 20) begin
			if (dp)
				v[62:52] = 11'(1023 - 30 + $urandom_range(0, 60));
			else
				v[30:23] = 8'(127 - 20 + $urandom_range(0, 40));
		end
		return v;
	endfunction

	task automatic push_beat(input logic [63:0] value, input logic last);
		beat_t b;
		b.value = value;
		b.last = last;
		pending_beats.push_back(b);
	endtask

	task automatic push_sequences(input int count, input bit close);
		int n;
		int len;
		n = 0;
		while (n < count) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				push_beat(rand_value(use_double),
					($urandom_range(0, 19) == 0) ? 1'b1 : (close || n + i + 1 < count) &&
					i == len - 1);
			n += len;
		end
	endtask

	task automatic drain();
		while (pending_beats.size() != 0 || expected_totals.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_DOUBLE)
			use_double = data;
		else
			use_kahan = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(input bit dp, input bit kahan);
		drain();
		write_reg(REG_DOUBLE, dp);
		write_reg(REG_COMPENSATE, kahan);
	endtask

	// sender
	always @(negedge clk) begin
		if (!s_tvalid || s_took) begin
			if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
				s_tdata <= pending_beats[0].value;
				s_tlast <= pending_beats[0].last;
				pending_beats.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_cnt <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(0, 99) >= 14;
		end
	end

	always @(posedge clk) begin
		s_took <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			accumulate(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_totals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected total %h", m_tdata);
			end else begin
				if (is_nan(expected_totals[0], use_double) ? !is_nan(m_tdata, use_double)
						: m_tdata !== expected_totals[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("total mismatch: expected %h actual %h",
							expected_totals[0], m_tdata);
				end
				expected_totals.pop_front();
			end
		end
		if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready) &&
				!(cfg_valid && cfg_ready))
			stall_cycles++;
		else
			stall_cycles = 0;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 1'b0;
		s_took = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		hold_cnt = 0;
		mismatches = 0;
		stall_cycles = 0;
		use_double = 1'b0;
		use_kahan = 1'b1;
		sum_bits = 0;
		err_bits = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single precision, compensated: zeros, overflow, inf, nan, subnormals
		push_beat(64'h0, 1'b0);
		push_beat(64'h8000_0000, 1'b1);
		push_beat(64'h8000_0000, 1'b1);
		push_beat(64'hFFFF_FFFF_7F7F_FFFF, 1'b0);
		push_beat(64'h0000_0000_7F7F_FFFF, 1'b0);
		push_beat(64'h3F80_0000, 1'b1);
		push_beat(64'h7F80_0000, 1'b0);
		push_beat(64'hFF80_0000, 1'b1);
		push_beat(64'h7FC0_0001, 1'b1);
		push_beat(64'h0000_0001, 1'b0);
		push_beat(64'h8000_0002, 1'b0);
		push_beat(64'h007F_FFFF, 1'b1);
		push_beat(64'h3F80_0000, 1'b0);
		for (int i = 0; i < 6; i++)
			push_beat(64'h3380_0000, 1'b0);
		push_beat(64'hBF80_0000, 1'b1);
		push_sequences(120, 1'b1);

		set_mode(1'b1, 1'b1);
		push_beat(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
		push_beat(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
		push_beat(64'h3FF0_0000_0000_0000, 1'b1);
		push_beat(64'h0000_0000_0000_0001, 1'b0);
		push_beat(64'h3FF0_0000_0000_0000, 1'b0);
		push_beat(64'h3CA0_0000_0000_0000, 1'b1);
		hold_req = 1'b1;
		calm = 1'b1;
		push_sequences(140, 1'b1);
		while (hold_cnt == 0) @(posedge clk);
		hold_req = 1'b0;

		set_mode(1'b1, 1'b0);
		push_sequences(140, 1'b0);
		while (pending_beats.size() > 60) @(posedge clk);
		calm = 1'b0;

		// open sequence carried across the precision change
		set_mode(1'b0, 1'b0);
		push_sequences(140, 1'b1);

		set_mode(1'b0, 1'b1);
		push_sequences(140, 1'b1);

		set_mode(1'b1, 1'b1);
		push_sequences(140, 1'b1);

		drain();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
